// ----- rtl/met_pkg.sv -----
// ----------------------------------------------------------------------------
// met_pkg
// Shared widths, configuration register indexes and the command and status
// bundles between the controller and the datapath of the escape-time grid.
// ----------------------------------------------------------------------------
package met_pkg;

  localparam int COORD_W = 32;
  localparam int STEP_W  = 31;
  localparam int DIM_W   = 13;
  localparam int ITER_W  = 16;
  localparam int CODE_W  = 17;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] CFG_CENTER_RE    = 3'd0;
  localparam logic [IDX_W-1:0] CFG_CENTER_IM    = 3'd1;
  localparam logic [IDX_W-1:0] CFG_PIXEL_STEP   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;
  localparam logic [IDX_W-1:0] CFG_MAX_ITER     = 3'd5;

  typedef struct packed {
    logic mul_pt;
    logic pt_im;
    logic ld_cre;
    logic ld_cim;
    logic clr_z;
    logic mul_z;
    logic upd_z;
  } met_cmd_t;

  typedef struct packed {
    logic esc;
    logic lim;
  } met_sts_t;

endpackage

// ----- rtl/mandelbrot_escape_time_grid.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_grid
// Escape-time raster generator: each request yields the next pixel of the
// frame, walked row by row from the lower left corner.
// ----------------------------------------------------------------------------
// Each round has two states: S_MUL registers three 32x32 products of z, then
// S_TEST updates z together with the escape test on those products. Rounds run
// until the escape round, or until the round count reaches max_iter (256 at
// reset) for a point that stays bounded. Point setup runs through the states
// S_PT_RE, S_PT_IM and S_INIT with a pair of step multipliers. A finished
// pixel waits in the output register while the next request is taken.
module mandelbrot_escape_time_grid
  import met_pkg::*;
#(
  parameter int MAX_SIDE  = 4096,
  parameter int FRAC_BITS = 28
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [IDX_W-1:0]                  cfg_index,
  input  logic [CFG_W-1:0]                  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [CODE_W-1:0]          out_iter_code,
  output logic [$clog2(MAX_SIDE)-1:0]       out_pixel_x,
  output logic [$clog2(MAX_SIDE)-1:0]       out_pixel_y,
  output logic                              out_last_of_frame
);

  localparam int POS_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = POS_W + 1;

  logic signed [COORD_W-1:0] center_re_r, center_im_r;
  logic [STEP_W-1:0]         pixel_step_r;
  logic [DIM_W-1:0]          frame_width_r, frame_height_r;
  logic [ITER_W-1:0]         max_iter_r;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [CODE_W-1:0]  code_r;
  logic [POS_W-1:0]          px_r, py_r;
  logic                      last_r;

  met_cmd_t                  cmd;
  met_sts_t                  sts;
  logic                      take, adv, ld_out, out_free;
  logic [SIDE_W-1:0]         eff_w, eff_h;
  logic [POS_W-1:0]          cur_x, cur_y;
  logic                      last;
  logic signed [CODE_W-1:0]  code;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_re_r    <= '0;
      center_im_r    <= '0;
      pixel_step_r   <= STEP_W'(2097152);
      frame_width_r  <= DIM_W'(800);
      frame_height_r <= DIM_W'(800);
      max_iter_r     <= ITER_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_RE:    center_re_r    <= cfg_wdata[COORD_W-1:0];
        CFG_CENTER_IM:    center_im_r    <= cfg_wdata[COORD_W-1:0];
        CFG_PIXEL_STEP:   pixel_step_r   <= cfg_wdata[STEP_W-1:0];
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[DIM_W-1:0];
        CFG_MAX_ITER:     max_iter_r     <= cfg_wdata[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  met_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .in_stall (in_stall),
    .take     (take),
    .adv      (adv),
    .ld_out   (ld_out),
    .cmd      (cmd)
  );

  met_raster #(
    .MAX_SIDE (MAX_SIDE)
  ) u_raster (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .take         (take),
    .restart      (in_restart),
    .adv          (adv),
    .eff_w        (eff_w),
    .eff_h        (eff_h),
    .cur_x        (cur_x),
    .cur_y        (cur_y),
    .last         (last)
  );

  met_dp #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .center_re  (center_re_r),
    .center_im  (center_im_r),
    .pixel_step (pixel_step_r),
    .max_iter   (max_iter_r),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .cur_x      (cur_x),
    .cur_y      (cur_y),
    .sts        (sts),
    .code       (code)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      code_r <= code;
      px_r   <= cur_x;
      py_r   <= cur_y;
      last_r <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_iter_code     = code_r;
  assign out_pixel_x       = px_r;
  assign out_pixel_y       = py_r;
  assign out_last_of_frame = last_r;

endmodule

// ----- rtl/met_raster.sv -----
// ----------------------------------------------------------------------------
// met_raster
// Raster walk: effective frame size, position of the pixel in work and the
// position of the next pixel.
// ----------------------------------------------------------------------------
module met_raster
  import met_pkg::*;
#(
  parameter int MAX_SIDE = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [DIM_W-1:0]              frame_width,
  input  logic [DIM_W-1:0]              frame_height,
  input  logic                          take,
  input  logic                          restart,
  input  logic                          adv,
  output logic [$clog2(MAX_SIDE):0]     eff_w,
  output logic [$clog2(MAX_SIDE):0]     eff_h,
  output logic [$clog2(MAX_SIDE)-1:0]   cur_x,
  output logic [$clog2(MAX_SIDE)-1:0]   cur_y,
  output logic                          last
);

  localparam int POS_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = POS_W + 1;

  logic [POS_W-1:0]  col_r, col_nxt;
  logic [POS_W-1:0]  row_r, row_nxt;
  logic [POS_W-1:0]  cur_x_r, cur_y_r;
  logic              last_r;
  logic [SIDE_W-1:0] px, py, py_t, nx, ny;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = SIDE_W'(1);
    end else if (32'(frame_width) > MAX_SIDE) begin
      eff_w = SIDE_W'(MAX_SIDE);
    end else begin
      eff_w = SIDE_W'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = SIDE_W'(1);
    end else if (32'(frame_height) > MAX_SIDE) begin
      eff_h = SIDE_W'(MAX_SIDE);
    end else begin
      eff_h = SIDE_W'(frame_height);
    end
  end

  // position of the pixel taken now, after a size change
  always_comb begin
    if (SIDE_W'(col_r) >= eff_w) begin
      px   = '0;
      py_t = SIDE_W'(row_r) + SIDE_W'(1);
    end else begin
      px   = SIDE_W'(col_r);
      py_t = SIDE_W'(row_r);
    end
    py = (py_t >= eff_h) ? '0 : py_t;
    if (restart) begin
      px = '0;
      py = '0;
    end
  end

  // next position after the pixel in work
  always_comb begin
    nx      = SIDE_W'(cur_x_r) + SIDE_W'(1);
    ny      = SIDE_W'(cur_y_r) + SIDE_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (adv) begin
      if (nx >= eff_w) begin
        col_nxt = '0;
        row_nxt = (ny >= eff_h) ? '0 : POS_W'(ny);
      end else begin
        col_nxt = POS_W'(nx);
        row_nxt = cur_y_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_x_r <= POS_W'(px);
      cur_y_r <= POS_W'(py);
      last_r  <= (px == eff_w - SIDE_W'(1)) && (py == eff_h - SIDE_W'(1));
    end
  end

  assign cur_x = cur_x_r;
  assign cur_y = cur_y_r;
  assign last  = last_r;

endmodule

// ----- rtl/met_dp.sv -----
// ----------------------------------------------------------------------------
// met_dp
// Datapath: pixel point setup and the z = z*z + c iteration with its escape
// test, in signed fixed point with saturation.
// ----------------------------------------------------------------------------
module met_dp
  import met_pkg::*;
#(
  parameter int MAX_SIDE  = 4096,
  parameter int FRAC_BITS = 28
) (
  input  logic                               clk,
  input  met_cmd_t                           cmd,
  input  logic signed [COORD_W-1:0]          center_re,
  input  logic signed [COORD_W-1:0]          center_im,
  input  logic [STEP_W-1:0]                  pixel_step,
  input  logic [ITER_W-1:0]                  max_iter,
  input  logic [$clog2(MAX_SIDE):0]          eff_w,
  input  logic [$clog2(MAX_SIDE):0]          eff_h,
  input  logic [$clog2(MAX_SIDE)-1:0]        cur_x,
  input  logic [$clog2(MAX_SIDE)-1:0]        cur_y,
  output met_sts_t                           sts,
  output logic signed [CODE_W-1:0]           code
);

  localparam int POS_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = POS_W + 1;
  localparam int PROD_W = STEP_W + SIDE_W;
  localparam int MUL_W  = 2 * COORD_W;
  localparam int SAT_W  = MUL_W + 2;
  localparam int ESC_SH = 2 * FRAC_BITS + 2;

  localparam logic signed [SAT_W-1:0] S_MAX =
    {{(SAT_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] S_MIN =
    {{(SAT_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  function automatic logic signed [COORD_W-1:0] sat_c(input logic signed [SAT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > S_MAX) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < S_MIN) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  logic [PROD_W-1:0]          prod_h_r, prod_o_r;
  logic signed [COORD_W-1:0]  c_re_r, c_im_r, a_r, b_r;
  logic signed [MUL_W-1:0]    aa_r, bb_r, ab_r;
  logic [ITER_W-1:0]          n_r;

  logic [SIDE_W-1:0]          side_sel;
  logic [POS_W-1:0]           pos_sel;
  logic signed [COORD_W-1:0]  center_sel;
  logic signed [SAT_W-1:0]    pt_sum;
  logic [MUL_W:0]             mag;
  logic signed [MUL_W:0]      diff, re_sh, im_sh;
  logic signed [SAT_W-1:0]    re_sum, im_sum;

  assign side_sel   = cmd.pt_im ? eff_h : eff_w;
  assign pos_sel    = cmd.pt_im ? cur_y : cur_x;
  assign center_sel = cmd.ld_cim ? center_im : center_re;

  assign pt_sum = SAT_W'(center_sel)
                - $signed(SAT_W'(prod_h_r >> 1))
                + $signed(SAT_W'(prod_o_r));

  // squared magnitude of the z whose products are held
  assign mag  = (MUL_W+1)'($unsigned(aa_r)) + (MUL_W+1)'($unsigned(bb_r));

  assign diff   = (MUL_W+1)'(aa_r) - (MUL_W+1)'(bb_r);
  assign re_sh  = diff >>> FRAC_BITS;
  assign im_sh  = (MUL_W+1)'(ab_r) >>> (FRAC_BITS - 1);
  assign re_sum = SAT_W'(re_sh) + SAT_W'(c_re_r);
  assign im_sum = SAT_W'(im_sh) + SAT_W'(c_im_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_pt) begin
      prod_h_r <= PROD_W'(pixel_step) * PROD_W'(side_sel - SIDE_W'(1));
      prod_o_r <= PROD_W'(pixel_step) * PROD_W'(pos_sel);
    end
    if (cmd.ld_cre) begin
      c_re_r <= sat_c(pt_sum);
    end
    if (cmd.ld_cim) begin
      c_im_r <= sat_c(pt_sum);
    end
    if (cmd.mul_z) begin
      aa_r <= MUL_W'(a_r) * MUL_W'(a_r);
      bb_r <= MUL_W'(b_r) * MUL_W'(b_r);
      ab_r <= MUL_W'(a_r) * MUL_W'(b_r);
    end
    if (cmd.clr_z) begin
      a_r <= '0;
      b_r <= '0;
      n_r <= '0;
    end else if (cmd.upd_z) begin
      a_r <= sat_c(re_sum);
      b_r <= sat_c(im_sum);
      n_r <= n_r + ITER_W'(1);
    end
  end

  assign sts.esc = (mag >> ESC_SH) != '0;
  assign sts.lim = (n_r == max_iter);
  assign code    = sts.esc ? -$signed(CODE_W'(n_r)) : $signed(CODE_W'(max_iter));

endmodule

// ----- rtl/met_ctrl.sv -----
// ----------------------------------------------------------------------------
// met_ctrl
// Controller: takes a request, sequences point setup and the iteration
// rounds, and hands the finished pixel to the output register.
// ----------------------------------------------------------------------------
module met_ctrl
  import met_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_free,
  input  met_sts_t sts,
  output logic     in_stall,
  output logic     take,
  output logic     adv,
  output logic     ld_out,
  output met_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PT_RE = 3'd1;
  localparam logic [2:0] S_PT_IM = 3'd2;
  localparam logic [2:0] S_INIT  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_TEST  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    take      = 1'b0;
    adv       = 1'b0;
    ld_out    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          take      = 1'b1;
          state_nxt = S_PT_RE;
        end
      end
      S_PT_RE: begin
        cmd.mul_pt = 1'b1;
        adv        = 1'b1;
        state_nxt  = S_PT_IM;
      end
      S_PT_IM: begin
        cmd.mul_pt = 1'b1;
        cmd.pt_im  = 1'b1;
        cmd.ld_cre = 1'b1;
        state_nxt  = S_INIT;
      end
      S_INIT: begin
        cmd.ld_cim = 1'b1;
        cmd.clr_z  = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul_z = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (sts.esc || sts.lim) begin
          state_nxt = S_OUT;
        end else begin
          cmd.upd_z = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ld_out    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
